// ----- sv/sha224_pkg.sv -----
package sha224_pkg;

   localparam int WordWidth = 32;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        last;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_PAD,
      ST_OUT
   } back_state_type;

   localparam logic [255:0] InitHash = {
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   function automatic word_type init_word(input logic [2:0] i);
      init_word = InitHash[(7 - i) * 32 +: 32];
   endfunction

   function automatic word_type round_k(input logic [5:0] r);
      logic [31:0] k;
      begin
         case (r)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
         endcase
         round_k = k;
      end
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ----- sv/sha224_queue.sv -----
module sha224_queue
   import sha224_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  item_type wr_item,
   output logic     rd_valid,
   input  logic     rd_ready,
   output item_type rd_item
);

   item_type   mem [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       wr, rd;

   assign wr_ready = (cnt_ff != 3'd4);
   assign rd_valid = (cnt_ff != 3'd0);
   assign wr       = wr_valid && wr_ready;
   assign rd       = rd_valid && rd_ready;
   assign rd_item  = mem[rp_ff];

   always_comb begin
      wp_in  = wr ? wp_ff + 2'd1 : wp_ff;
      rp_in  = rd ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + {2'b0, wr} - {2'b0, rd};
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem[wp_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- sv/sha224_core.sv -----
module sha224_core
   import sha224_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  item_type    in_item,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_word,
   output logic        out_last
);

   back_state_type state_ff, state_in;
   word_type    h_ff [8];
   word_type    v_ff [8];
   word_type    w_ff [16];
   logic [5:0]  rnd_ff;
   logic [3:0]  widx_ff;
   logic [63:0] bits_ff;
   logic [1:0]  pad_ff;
   logic [2:0]  oidx_ff;
   logic        ovalid_ff;
   logic [31:0] oword_ff;
   logic        olast_ff;

   logic [2:0]  nb;
   logic [31:0] push_w, keep, mask, marker;
   logic        do_push;
   logic [31:0] s0, s1, wr_sched, wnow, t1, t2;
   logic        obuf_free;

   assign obuf_free = !ovalid_ff || out_ready;
   assign nb        = (in_item.nbytes > 3'd4) ? 3'd4 : in_item.nbytes;
   assign in_ready  = (state_ff == ST_IDLE);

   always_comb begin
      mask   = (nb == 3'd0) ? 32'h0 : (32'hffffffff << (6'd32 - {nb, 3'b000}));
      marker = 32'h80 << (5'd24 - {nb[1:0], 3'b000});
      keep   = (in_item.data & mask) | marker;
   end

   always_comb begin
      s0 = rotr(w_ff[rnd_ff[3:0] + 4'd1], 7) ^ rotr(w_ff[rnd_ff[3:0] + 4'd1], 18)
         ^ (w_ff[rnd_ff[3:0] + 4'd1] >> 3);
      s1 = rotr(w_ff[rnd_ff[3:0] + 4'd14], 17) ^ rotr(w_ff[rnd_ff[3:0] + 4'd14], 19)
         ^ (w_ff[rnd_ff[3:0] + 4'd14] >> 10);
      wr_sched = w_ff[rnd_ff[3:0]] + s0 + w_ff[rnd_ff[3:0] + 4'd9] + s1;
      wnow = (rnd_ff < 6'd16) ? w_ff[rnd_ff[3:0]] : wr_sched;
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_k(rnd_ff) + wnow;
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      do_push = 1'b0;
      push_w  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               do_push = 1'b1;
               if (!in_item.last || nb == 3'd4) begin
                  push_w = in_item.data;
               end else begin
                  push_w = keep;
               end
            end
         end
         ST_PAD: begin
            do_push = 1'b1;
            if (pad_ff == 2'd1) begin
               push_w = (widx_ff == 4'd14) ? bits_ff[63:32] : 32'h0;
            end else if (pad_ff == 2'd2) begin
               push_w = bits_ff[31:0];
            end else begin
               push_w = 32'h80000000;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               if (widx_ff == 4'd15) begin
                  state_in = ST_LOAD;
               end else if (in_item.last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD:    state_in = (widx_ff == 4'd15) ? ST_LOAD : ST_PAD;
         ST_LOAD:   state_in = ST_ROUND;
         ST_ROUND:  state_in = (rnd_ff == 6'd63) ? ST_UPDATE : ST_ROUND;
         ST_UPDATE: begin
            if (pad_ff == 2'd2 && widx_ff == 4'd0) begin
               state_in = ST_OUT;
            end else if (pad_ff != 2'd0) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT:    state_in = (obuf_free && oidx_ff == 3'd6) ? ST_IDLE : ST_OUT;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         w_ff[widx_ff] <= push_w;
      end else if (state_ff == ST_ROUND && rnd_ff >= 6'd16) begin
         w_ff[rnd_ff[3:0]] <= wr_sched;
      end
      if (state_ff == ST_LOAD) begin
         for (int k = 0; k < 8; k++) v_ff[k] <= h_ff[k];
      end else if (state_ff == ST_ROUND) begin
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
      if (obuf_free && state_ff == ST_OUT) begin
         oword_ff <= h_ff[oidx_ff];
         olast_ff <= (oidx_ff == 3'd6);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rnd_ff    <= '0;
         widx_ff   <= '0;
         bits_ff   <= '0;
         pad_ff    <= '0;
         oidx_ff   <= '0;
         ovalid_ff <= 1'b0;
         for (int k = 0; k < 8; k++) h_ff[k] <= init_word(3'(k));
      end else begin
         state_ff <= state_in;
         if (do_push) begin
            widx_ff <= widx_ff + 4'd1;
         end
         if (state_ff == ST_IDLE && in_valid) begin
            if (!in_item.last) begin
               bits_ff <= bits_ff + 64'd32;
            end else begin
               bits_ff <= bits_ff + {58'd0, nb, 3'b000};
               pad_ff  <= (nb == 3'd4) ? 2'd3 : 2'd1;
            end
         end
         if (state_ff == ST_PAD && pad_ff == 2'd3) begin
            pad_ff <= 2'd1;
         end else if (state_ff == ST_PAD && pad_ff == 2'd1 && widx_ff == 4'd14) begin
            pad_ff <= 2'd2;
         end
         if (state_ff == ST_ROUND) begin
            rnd_ff <= rnd_ff + 6'd1;
         end
         if (state_ff == ST_UPDATE) begin
            for (int k = 0; k < 8; k++) h_ff[k] <= h_ff[k] + v_ff[k];
         end
         if (state_ff == ST_OUT && obuf_free) begin
            ovalid_ff <= 1'b1;
            if (oidx_ff == 3'd6) begin
               oidx_ff <= '0;
               bits_ff <= '0;
               pad_ff  <= '0;
               widx_ff <= '0;
               for (int k = 0; k < 8; k++) h_ff[k] <= init_word(3'(k));
            end else begin
               oidx_ff <= oidx_ff + 3'd1;
            end
         end else if (out_ready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   assign out_valid = ovalid_ff;
   assign out_word  = oword_ff;
   assign out_last  = olast_ff;

endmodule

// ----- sv/sha224_hash_engine.sv -----
// channel | direction | tdata                  | tuser | tlast
// req_    | in        | [31:0] data_word        | -     | last
//         |           | [34:32] valid_bytes     |       |
// rsp_    | out       | [31:0] digest_word      | -     | digest_last
// A block compresses in steps: load, 64 rounds, update, with one round per cycle.
// Non-last words pass back to back unless they complete a block; a four-deep queue
// takes words while a block compresses. Padding writes one word a cycle.
// Synchronous active-high reset restores the SHA-224 initial chaining values.
// The digest leaves through a one-entry output register; rsp_tready stalls it.
module sha224_hash_engine
   import sha224_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // data_word[31:0], valid_bytes[34:32], zero
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // digest_word[31:0]
   output logic        rsp_tlast
);

   item_type wr_item, rd_item;
   logic     q_valid, q_ready;

   assign wr_item = '{data: req_tdata[31:0], nbytes: req_tdata[34:32], last: req_tlast};

   sha224_queue u_queue (
      .clock, .reset,
      .wr_valid (req_tvalid), .wr_ready (req_tready), .wr_item (wr_item),
      .rd_valid (q_valid), .rd_ready (q_ready), .rd_item (rd_item)
   );

   sha224_core u_core (
      .clock, .reset,
      .in_valid (q_valid), .in_ready (q_ready), .in_item (rd_item),
      .out_valid (rsp_tvalid), .out_ready (rsp_tready),
      .out_word (rsp_tdata), .out_last (rsp_tlast)
   );

endmodule

// ----- sim/sha224_checker.sv -----
`timescale 1ns / 100ps

module sha224_checker
   import sha224_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          digests_pending
);

   typedef struct {
      logic [31:0] word;
      logic        last;
   } digest_word_type;

   logic [31:0]     chain_h [8];
   logic [31:0]     block_w [16];
   logic [3:0]      slot;
   logic [63:0]     bit_length;
   digest_word_type digest_queue [$];

   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] Sha224Iv [8] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] v [8];
      logic [31:0] w [64];
      logic [31:0] t1, t2, s0, s1;
      for (int k = 0; k < 8; k++) v[k] = chain_h[k];
      for (int r = 0; r < 64; r++) begin
         if (r < 16) begin
            w[r] = block_w[r];
         end else begin
            s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = w[r-16] + s0 + w[r-7] + s1;
         end
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w[r];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int k = 0; k < 8; k++) chain_h[k] = chain_h[k] + v[k];
   endtask

   task automatic append_word(input logic [31:0] w);
      block_w[slot] = w;
      slot = slot + 4'd1;
      if (slot == 4'd0) compress_block();
   endtask

   task automatic start_message();
      for (int k = 0; k < 8; k++) chain_h[k] = Sha224Iv[k];
      slot = '0;
      bit_length = '0;
   endtask

   task automatic absorb_word(input logic [31:0] data, input logic [2:0] nbytes,
                              input logic is_last);
      int nb;
      logic [31:0] keep;
      digest_word_type d;
      if (!is_last) begin
         append_word(data);
         bit_length += 64'd32;
         return;
      end
      nb = (nbytes > 3'd4) ? 4 : int'(nbytes);
      bit_length += 64'(8 * nb);
      if (nb == 4) begin
         append_word(data);
         append_word(32'h8000_0000);
      end else begin
         keep = (nb > 0) ? (data & (32'hFFFF_FFFF << (32 - 8 * nb))) : 32'h0;
         keep |= 32'h80 << (24 - 8 * nb);
         append_word(keep);
      end
      while (slot != 4'd14) append_word(32'h0);
      append_word(bit_length[63:32]);
      append_word(bit_length[31:0]);
      for (int k = 0; k < 7; k++) begin
         d.word = chain_h[k];
         d.last = (k == 6);
         digest_queue.push_back(d);
      end
      start_message();
   endtask

   assign digests_pending = digest_queue.size();

   always @(posedge clock) begin
      digest_word_type d;
      if (reset) begin
         start_message();
         digest_queue.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            absorb_word(req_tdata[31:0], req_tdata[34:32], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected digest transaction %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               fail_count <= fail_count + 1;
            end else begin
               d = digest_queue.pop_front();
               if (rsp_tdata !== d.word || rsp_tlast !== d.last) begin
                  $display("%0t: digest mismatch expected %h last %b actual %h last %b",
                           $time, d.word, d.last, rsp_tdata, rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- sim/tb_sha224_hash_engine.sv -----
`timescale 1ns / 100ps

module tb_sha224_hash_engine;
   import sha224_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          digests_pending;
   bit          sending_done;
   bit          long_hold;

   sha224_hash_engine i_dut (.*);

   sha224_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                            input logic is_last);
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, nbytes, data};
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_message(input int nwords, input logic [2:0] tail_bytes,
                               input logic [31:0] fill);
      for (int k = 0; k < nwords - 1; k++)
         send_word((fill == 32'h0) ? $urandom() : fill, 3'($urandom_range(0, 7)), 1'b0);
      send_word((fill == 32'h0) ? $urandom() : fill, tail_bytes, 1'b1);
   endtask

   initial begin
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      reset        = 1'b1;
      sending_done = 1'b0;
      long_hold    = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: every tail size, length fitting and not fitting, extremes
      send_message(1, 3'd0, 32'h0);
      send_message(1, 3'd4, 32'hFFFF_FFFF);
      send_message(1, 3'd7, 32'h0);
      for (int nb = 1; nb < 4; nb++) send_message(1, 3'(nb), 32'hFFFF_FFFF);
      send_message(14, 3'd4, 32'h0);
      send_message(14, 3'd1, 32'h0);
      long_hold <= 1'b1;
      send_message(16, 3'd3, 32'h0);
      send_message(17, 3'd0, 32'h0);
      long_hold <= 1'b0;
      for (int m = 0; m < 6; m++)
         send_message($urandom_range(1, 20), 3'($urandom_range(0, 7)), 32'h0);
      send_message(20, 3'd2, 32'h0);
      req_tvalid   <= 1'b0;
      sending_done <= 1'b1;
   end

   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(0, 4) != 0) || ($urandom_range(0, 1) == 0);
         repeat ($urandom_range(0, 4)) @(posedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      @(posedge sending_done);
      while (digests_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_sha224_hash_engine passed");
      end else begin
         $display("tb_sha224_hash_engine failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("tb_sha224_hash_engine failed");
      $finish;
   end

endmodule

// ----- files.f -----
sv/sha224_pkg.sv
sv/sha224_queue.sv
sv/sha224_core.sv
sv/sha224_hash_engine.sv
sim/sha224_checker.sv
sim/tb_sha224_hash_engine.sv
